[sv/ed_pkg.sv]
// ----------------------------------------------------------------------------
// ed_pkg: shared definitions for the edit distance engine
// Field widths, request kinds, sequencer states and the default word length.
// ----------------------------------------------------------------------------
`default_nettype none

package ed_pkg;

  localparam int unsigned MAX_LEN_DEF = 256;
  localparam int unsigned SYM_W       = 8;
  localparam int unsigned DIST_W      = 9;
  localparam int unsigned OUT_DATA_W  = 16;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FIRST = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_OUT
  } state_e;

endpackage

`default_nettype wire

[sv/ed_cell.sv]
// ----------------------------------------------------------------------------
// ed_cell: shared cell update unit
// Computes one entry of the new row from its left, diagonal and upper
// neighbors and the match of the two characters.
// ----------------------------------------------------------------------------
`default_nettype none

module ed_cell #(
  parameter int unsigned VW = 9
) (
  input  wire logic [ed_pkg::SYM_W-1:0] sym_i,
  input  wire logic [ed_pkg::SYM_W-1:0] pat_i,
  input  wire logic [VW-1:0]            left_i,
  input  wire logic [VW-1:0]            diag_i,
  input  wire logic [VW-1:0]            up_i,
  output logic      [VW-1:0]            val_o
);

  logic [VW-1:0] best;

  always_comb begin
    best = left_i;
    if (diag_i < best) best = diag_i;
    if (up_i < best) best = up_i;
    if (sym_i == pat_i) begin
      val_o = diag_i;
    end else begin
      val_o = best + VW'(1);
    end
  end

endmodule

`default_nettype wire

[sv/ed_mem.sv]
// ----------------------------------------------------------------------------
// ed_mem: simple dual-port memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ed_mem #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [W-1:0]  wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [W-1:0]  rdata_o
);

  logic [W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[sv/edit_distance_engine.sv]
// ----------------------------------------------------------------------------
// edit_distance_engine: Levenshtein edit distance with unit costs
// Holds a second word and compares first words against it, one row of the
// dynamic-programming table updated per first-word character.
// ----------------------------------------------------------------------------
// Input stream: tdata carries the character, tuser the kind (0 loads a
// character of the second word, 1 feeds a character of the first word),
// tlast marks the final character of either word.
// A second-word character is taken in the idle state, which the block does
// not leave for it, so it stays ready. A first-word character walks the m
// entries of the stored row through one shared cell unit, one entry per
// cycle, and the block takes no input until it is idle again (m = stored
// second-word length, at most MAX_LEN); the row memory read is registered.
// The final first-word character yields one result on the output stream:
// tdata holds the distance, tuser the overflow flag. After the row walk the
// block passes to its output state and fills the output register, which
// frees the input side again; if the receiver stalls while a second result
// is due, the block holds in its output state until the register drains.
// Reset clears the sequencer and flags; the word and row memories are not
// cleared, the first row after a load is generated on the fly.
// ----------------------------------------------------------------------------
`default_nettype none

module edit_distance_engine #(
  parameter int unsigned MAX_LEN = ed_pkg::MAX_LEN_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [ed_pkg::SYM_W-1:0]      s_axis_tdata,   // [7:0] symbol
  input  wire logic                          s_axis_tuser,   // [0] operation
  input  wire logic                          s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic      [ed_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // [8:0] distance
  output logic                               m_axis_tuser    // [0] overflow
);

  localparam int unsigned LW = $clog2(MAX_LEN + 1);
  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  ed_pkg::state_e state_q, state_d;

  logic [LW-1:0] pat_len_q;
  logic [LW-1:0] row_idx_q;
  logic          ovf_flag_q;
  logic          word_ovf_q;
  logic          loading_q;
  logic          fresh_q;
  logic          last_q;
  logic [LW-1:0] rk_q;
  logic          pend_q;
  logic [AW-1:0] wk_q;
  logic [ed_pkg::SYM_W-1:0] sym_q;
  logic [LW-1:0] left_q;
  logic [LW-1:0] diag_q;
  logic [LW-1:0] tail_q;
  logic          m_valid_q;
  logic [ed_pkg::DIST_W-1:0] m_dist_q;
  logic          m_ovf_q;

  logic          accept;
  logic          is_load;
  logic          is_first;
  logic          start_run;
  logic          ovf_char;
  logic          issue;
  logic          done_run;
  logic          out_free;
  logic          emit;
  logic [LW-1:0] eff_len;
  logic          pat_we;
  logic [ed_pkg::SYM_W-1:0] pat_rd;
  logic [LW-1:0] row_rd;
  logic [LW-1:0] up_val;
  logic [LW-1:0] cell_val;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign is_load   = accept && (s_axis_tuser == ed_pkg::OP_LOAD);
  assign is_first  = accept && (s_axis_tuser == ed_pkg::OP_FIRST) && !loading_q;
  assign start_run = is_first && (row_idx_q < LW'(MAX_LEN));
  assign ovf_char  = is_first && !(row_idx_q < LW'(MAX_LEN));
  assign out_free  = !m_valid_q || m_axis_tready;
  assign eff_len   = loading_q ? pat_len_q : '0;
  assign pat_we    = is_load && (eff_len < LW'(MAX_LEN));
  assign up_val    = fresh_q ? (LW'(wk_q) + LW'(1)) : row_rd;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ed_pkg::ST_IDLE: begin
        if (start_run) begin
          state_d = ed_pkg::ST_RUN;
        end else if (ovf_char && s_axis_tlast) begin
          state_d = ed_pkg::ST_OUT;
        end
      end
      ed_pkg::ST_RUN: begin
        if (done_run) state_d = last_q ? ed_pkg::ST_OUT : ed_pkg::ST_IDLE;
      end
      ed_pkg::ST_OUT: begin
        if (out_free) state_d = ed_pkg::ST_IDLE;
      end
      default: state_d = ed_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    issue         = 1'b0;
    done_run      = 1'b0;
    emit          = 1'b0;
    unique case (state_q)
      ed_pkg::ST_IDLE: s_axis_tready = 1'b1;
      ed_pkg::ST_RUN: begin
        issue    = (rk_q < pat_len_q);
        done_run = !(rk_q < pat_len_q) && !pend_q;
      end
      ed_pkg::ST_OUT: emit = out_free;
      default: ;
    endcase
  end

  ed_mem #(
    .W    (ed_pkg::SYM_W),
    .DEPTH(MAX_LEN),
    .AW   (AW)
  ) u_pat_mem (
    .clk_i  (clk_i),
    .we_i   (pat_we),
    .waddr_i(eff_len[AW-1:0]),
    .wdata_i(s_axis_tdata),
    .raddr_i(rk_q[AW-1:0]),
    .rdata_o(pat_rd)
  );

  ed_mem #(
    .W    (LW),
    .DEPTH(MAX_LEN),
    .AW   (AW)
  ) u_row_mem (
    .clk_i  (clk_i),
    .we_i   (pend_q),
    .waddr_i(wk_q),
    .wdata_i(cell_val),
    .raddr_i(rk_q[AW-1:0]),
    .rdata_o(row_rd)
  );

  ed_cell #(
    .VW(LW)
  ) u_cell (
    .sym_i (sym_q),
    .pat_i (pat_rd),
    .left_i(left_q),
    .diag_i(diag_q),
    .up_i  (up_val),
    .val_o (cell_val)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ed_pkg::ST_IDLE;
      pat_len_q  <= '0;
      row_idx_q  <= '0;
      ovf_flag_q <= 1'b0;
      word_ovf_q <= 1'b0;
      loading_q  <= 1'b1;
      fresh_q    <= 1'b1;
      last_q     <= 1'b0;
      rk_q       <= '0;
      pend_q     <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= issue;
      if (issue) rk_q <= rk_q + LW'(1);

      if (is_load) begin
        loading_q <= !s_axis_tlast;
        if (!loading_q || s_axis_tlast) begin
          word_ovf_q <= 1'b0;
          row_idx_q  <= '0;
        end
        if (eff_len < LW'(MAX_LEN)) begin
          pat_len_q  <= eff_len + LW'(1);
          ovf_flag_q <= loading_q ? ovf_flag_q : 1'b0;
        end else begin
          pat_len_q  <= eff_len;
          ovf_flag_q <= 1'b1;
        end
        if (s_axis_tlast) fresh_q <= 1'b1;
      end

      if (start_run) begin
        rk_q      <= '0;
        row_idx_q <= row_idx_q + LW'(1);
        last_q    <= s_axis_tlast;
      end

      if (ovf_char) begin
        word_ovf_q <= 1'b1;
        last_q     <= s_axis_tlast;
      end

      if (done_run) fresh_q <= 1'b0;

      if (emit) begin
        m_valid_q  <= 1'b1;
        fresh_q    <= 1'b1;
        row_idx_q  <= '0;
        word_ovf_q <= 1'b0;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (start_run) begin
      sym_q  <= s_axis_tdata;
      diag_q <= row_idx_q;
      left_q <= row_idx_q + LW'(1);
    end
    if (issue) wk_q <= rk_q[AW-1:0];
    if (pend_q) begin
      left_q <= cell_val;
      diag_q <= up_val;
      tail_q <= cell_val;
    end
    if (emit) begin
      m_dist_q <= ed_pkg::DIST_W'(tail_q);
      m_ovf_q  <= ovf_flag_q || word_ovf_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = ed_pkg::OUT_DATA_W'(m_dist_q);
  assign m_axis_tuser  = m_ovf_q;

endmodule

`default_nettype wire

[sv/ed_checker.sv]
// ----------------------------------------------------------------------------
// ed_checker: port-level checks for the edit distance engine
// Watches the two streams of the top level and is bound to it.
// ----------------------------------------------------------------------------
`default_nettype none

module ed_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tvalid,
  input wire logic                          s_axis_tready,
  input wire logic                          s_axis_tuser,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [ed_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic                          m_axis_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // padding above the distance stays zero
  a_out_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[ed_pkg::OUT_DATA_W-1:ed_pkg::DIST_W] == '0))
    else $error("distance padding not zero");

  // a second-word request never raises a result in the next cycle
  a_load_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == ed_pkg::OP_LOAD) |=>
      !$rose(m_axis_tvalid))
    else $error("result raised by a load request");

endmodule

bind edit_distance_engine ed_checker u_ed_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tuser (s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

`default_nettype wire

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the edit distance engine
// Streams second-word and first-word characters into the block, keeps a
// software copy of the stored word and the distance row, and checks every
// distance and overflow flag that comes out against it, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  localparam int unsigned MAXL      = ed_pkg::MAX_LEN_DEF;
  localparam int unsigned ITEMS     = 1950;
  localparam int unsigned HOLD_LEN  = 3000;
  localparam int unsigned TAIL_CYC  = 300;
  localparam int unsigned DRAIN_MAX = 300000;

  typedef struct {
    logic       op;
    logic [7:0] sym;
    logic       last;
    logic       drain;
  } char_req_t;

  typedef struct {
    logic [8:0] dval;
    logic       ovf;
  } dist_res_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        s_axis_tvalid  = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata   = '0;  // [7:0] symbol
  logic        s_axis_tuser   = 1'b0; // [0] operation
  logic        s_axis_tlast   = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready  = 1'b0;
  logic [15:0] m_axis_tdata;          // [8:0] distance
  logic        m_axis_tuser;          // [0] overflow

  char_req_t   pending_chars[$];
  dist_res_t   due_distances[$];
  char_req_t   cur_char;
  dist_res_t   want;

  logic [7:0]  b_word [MAXL];
  int unsigned b_len;
  int unsigned dp_row [MAXL+1];
  int unsigned a_rows;
  bit          b_long;
  bit          a_long;
  bit          b_loading;

  logic [7:0]  abc [4];
  int unsigned n_real;
  int unsigned n_total;
  int unsigned n_acc;
  int unsigned n_err;
  int unsigned bnd1;
  int unsigned bnd2;
  int unsigned hold_at;
  int unsigned hold_left;
  bit          held;

  edit_distance_engine i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic reset_row();
    for (int unsigned j = 0; j <= b_len; j++) dp_row[j] = j;
    a_rows = 0;
    a_long = 1'b0;
  endtask

  task automatic edit_step(input char_req_t r);
    int unsigned diag;
    int unsigned up;
    int unsigned best;
    int unsigned cval;
    dist_res_t   res;
    if (r.op == ed_pkg::OP_LOAD) begin
      if (!b_loading) begin
        b_loading = 1'b1;
        b_len     = 0;
        b_long    = 1'b0;
        a_long    = 1'b0;
        a_rows    = 0;
      end
      if (b_len < MAXL) begin
        b_word[b_len] = r.sym;
        b_len++;
      end else begin
        b_long = 1'b1;
      end
      if (r.last) begin
        b_loading = 1'b0;
        reset_row();
      end
    end else if (!b_loading) begin
      if (a_rows < MAXL) begin
        a_rows++;
        diag      = dp_row[0];
        dp_row[0] = a_rows;
        for (int unsigned j = 1; j <= b_len; j++) begin
          up = dp_row[j];
          if (r.sym == b_word[j-1]) begin
            cval = diag;
          end else begin
            best = dp_row[j-1];
            if (diag < best) best = diag;
            if (up < best) best = up;
            cval = best + 1;
          end
          diag      = up;
          dp_row[j] = cval;
        end
      end else begin
        a_long = 1'b1;
      end
      if (r.last) begin
        res.dval = 9'(dp_row[b_len]);
        res.ovf  = b_long || a_long;
        due_distances.push_back(res);
        reset_row();
      end
    end
  endtask

  task automatic push_char(input logic op, input logic [7:0] sym, input logic last);
    char_req_t r;
    r.op    = op;
    r.sym   = sym;
    r.last  = last;
    r.drain = 1'b0;
    pending_chars.push_back(r);
  endtask

  function automatic logic [7:0] pick_sym();
    if ($urandom_range(99) < 75) return abc[$urandom_range(3)];
    return 8'($urandom_range(255));
  endfunction

  task automatic load_word(input int unsigned len);
    int unsigned noise_at;
    for (int k = 0; k < 4; k++) abc[k] = 8'($urandom_range(255));
    noise_at = (len >= 2 && $urandom_range(99) < 10) ? $urandom_range(1, len - 1) : 0;
    for (int unsigned i = 0; i < len; i++) begin
      // stray first-word character while the second word is still loading
      if (noise_at != 0 && i == noise_at)
        push_char(ed_pkg::OP_FIRST, 8'($urandom_range(255)), 1'($urandom_range(1)));
      push_char(ed_pkg::OP_LOAD, pick_sym(), i == len - 1);
      n_real++;
    end
  endtask

  task automatic feed_word(input int unsigned len, input bit finish);
    for (int unsigned i = 0; i < len; i++) begin
      push_char(ed_pkg::OP_FIRST, pick_sym(), finish && i == len - 1);
      n_real++;
    end
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
      s_axis_tlast  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        edit_step(cur_char);
        n_acc++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_chars.size() != 0
            && !(pending_chars[0].drain && due_distances.size() != 0)
            && $urandom_range(99) >= ((n_acc < bnd1) ? 7 : (n_acc < bnd2) ? 79 : 0)) begin
          cur_char      = pending_chars.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= cur_char.sym;
          s_axis_tuser  <= cur_char.op;
          s_axis_tlast  <= cur_char.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result receiver with one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (hold_left != 0) begin
        hold_left--;
      end else if (!held && n_acc >= hold_at) begin
        hold_left = HOLD_LEN;
        held      = 1'b1;
      end
      m_axis_tready <= (hold_left == 0)
                       && $urandom_range(99) >= ((n_acc < bnd1) ? 79 : (n_acc < bnd2) ? 7 : 0);
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (due_distances.size() == 0) begin
        n_err++;
        if (n_err <= 10)
          $display("unexpected result: distance %0d overflow %0b",
                   m_axis_tdata, m_axis_tuser);
      end else begin
        want = due_distances.pop_front();
        if (m_axis_tdata !== {7'b0, want.dval} || m_axis_tuser !== want.ovf) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch: distance exp %0d got %0d, overflow exp %0b got %0b",
                     want.dval, m_axis_tdata, want.ovf, m_axis_tuser);
        end
      end
    end
  end

  initial begin
    #50_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int unsigned plen;
    int unsigned nw;
    int unsigned wl;
    int unsigned r;
    b_len     = 0;
    a_rows    = 0;
    b_long    = 1'b0;
    a_long    = 1'b0;
    b_loading = 1'b1;
    n_real    = 0;
    n_acc     = 0;
    n_err     = 0;
    hold_left = 0;
    held      = 1'b0;
    bnd1      = '1;
    bnd2      = '1;
    hold_at   = '1;

    // first word before any second word is ignored
    push_char(ed_pkg::OP_FIRST, 8'h00, 1'b1);
    push_char(ed_pkg::OP_LOAD,  8'hff, 1'b1);
    push_char(ed_pkg::OP_FIRST, 8'hff, 1'b1);
    push_char(ed_pkg::OP_FIRST, 8'h00, 1'b1);
    // new second word, with a first-word character during its load
    push_char(ed_pkg::OP_LOAD,  8'h00, 1'b0);
    push_char(ed_pkg::OP_FIRST, 8'h55, 1'b1);
    push_char(ed_pkg::OP_LOAD,  8'h80, 1'b0);
    push_char(ed_pkg::OP_LOAD,  8'hff, 1'b1);
    push_char(ed_pkg::OP_FIRST, 8'h00, 1'b0);
    push_char(ed_pkg::OP_FIRST, 8'h80, 1'b0);
    push_char(ed_pkg::OP_FIRST, 8'hff, 1'b1);
    push_char(ed_pkg::OP_FIRST, 8'h01, 1'b0);
    push_char(ed_pkg::OP_FIRST, 8'h02, 1'b1);
    push_char(ed_pkg::OP_FIRST, 8'h80, 1'b1);
    push_char(ed_pkg::OP_FIRST, 8'hff, 1'b0);
    push_char(ed_pkg::OP_FIRST, 8'h00, 1'b0);
    push_char(ed_pkg::OP_FIRST, 8'h80, 1'b0);
    push_char(ed_pkg::OP_FIRST, 8'hff, 1'b1);
    n_real = 16;

    // full-length and overlong second words, overlong first word
    load_word(MAXL);
    feed_word(3, 1'b1);
    load_word(MAXL + 2);
    feed_word(2, 1'b1);
    feed_word(4, 1'b1);
    load_word(2);
    feed_word(MAXL + 2, 1'b1);
    feed_word(3, 1'b1);

    while (n_real < ITEMS) begin
      r = $urandom_range(99);
      if (r < 80)      plen = $urandom_range(1, 8);
      else if (r < 95) plen = $urandom_range(9, 32);
      else if (r < 98) plen = $urandom_range(200, MAXL);
      else             plen = $urandom_range(MAXL + 1, MAXL + 4);
      load_word(plen);
      nw = $urandom_range(1, 4);
      for (int unsigned w = 0; w < nw; w++) begin
        if (plen > 32)                     wl = $urandom_range(1, 3);
        else if ($urandom_range(99) < 10)  wl = $urandom_range(20, 40);
        else                               wl = $urandom_range(1, 10);
        feed_word(wl, $urandom_range(99) >= 8);
      end
    end

    n_total = pending_chars.size();
    bnd1    = n_total / 3;
    bnd2    = 2 * n_total / 3;
    hold_at = (bnd2 + n_total) / 2;
    pending_chars[bnd1].drain = 1'b1;
    pending_chars[bnd2].drain = 1'b1;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (n_acc == n_total);
    for (int unsigned k = 0; k < DRAIN_MAX && due_distances.size() != 0; k++)
      @(posedge clk_i);
    repeat (TAIL_CYC) @(posedge clk_i);
    if (due_distances.size() != 0) n_err += due_distances.size();

    if (n_err == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
sv/ed_pkg.sv
sv/ed_cell.sv
sv/ed_mem.sv
sv/edit_distance_engine.sv
sv/ed_checker.sv
verif/testbench.sv
